// ----- src/awbl_pkg.sv -----
// Package for the auto white balance levels block.
// Holds payload structs, codes, state enums and arithmetic constants.
// No dependencies.
package awbl_pkg;

  localparam int AWBL_PIXEL_COUNT_BITS = 24;

  // Luma and chroma weights, Q16
  localparam logic [15:0] AWBL_Y_R = 16'd19595;
  localparam logic [15:0] AWBL_Y_G = 16'd38470;
  localparam logic [15:0] AWBL_Y_B = 16'd7471;
  localparam logic [16:0] AWBL_CB_K = 17'd36962;
  localparam logic [16:0] AWBL_CR_K = 17'd46727;
  localparam logic [7:0]  AWBL_CHROMA_OFS = 8'd128;
  localparam logic [7:0]  AWBL_MID_LEVEL = 8'd127;

  localparam logic [7:0]  AWBL_THR_RESET  = 8'd15;
  localparam logic [16:0] AWBL_CUT_RESET  = 17'd655;
  localparam logic [16:0] AWBL_GAIN_RESET = 17'd58982;

  typedef enum logic [1:0] {
    CFG_THRESHOLD = 2'd0,
    CFG_CUT       = 2'd1,
    CFG_GAIN      = 2'd2
  } awbl_cfg_idx_t;

  typedef enum logic {
    REQ_GATHER = 1'b0,
    REQ_APPLY  = 1'b1
  } awbl_req_t;

  typedef enum logic {
    KIND_STATUS = 1'b0,
    KIND_PIXEL  = 1'b1
  } awbl_kind_t;

  typedef struct packed {
    logic       req_type;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } awbl_in_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       color_cast;
  } awbl_out_t;

  typedef struct packed {
    logic incr;
    logic build;
    logic empty;
  } awbl_lane_cmd_t;

  typedef enum logic [3:0] {
    S_IDLE, S_G1, S_G2, S_G3, S_G4, S_PREP, S_LAUNCH, S_BUILD, S_APPLY, S_EMIT
  } awbl_state_t;

  typedef enum logic [2:0] {
    L_IDLE, L_UP, L_DOWN, L_MUL, L_CLAMP, L_DIV, L_FILL
  } awbl_lane_state_t;

  typedef enum logic [1:0] {
    C_IDLE, C_PREP, C_DIV, C_FIN
  } awbl_cast_state_t;

endpackage

// ----- src/awbl_lane.sv -----
// One colour channel lane: histogram store, level scan and lookup table build.
// Depends on awbl_pkg.
module awbl_lane import awbl_pkg::*; #(
  parameter int PIXEL_COUNT_BITS = AWBL_PIXEL_COUNT_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  awbl_lane_cmd_t               cmd,
  input  logic [7:0]                   pix,
  input  logic [PIXEL_COUNT_BITS+17:0] need,
  input  logic [16:0]                  gain,
  output logic [7:0]                   lut_q,
  output logic                         done
);

  localparam int CNT_W  = PIXEL_COUNT_BITS + 1;
  localparam int NEED_W = PIXEL_COUNT_BITS + 18;

  awbl_lane_state_t state_r, state_nxt;

  logic [CNT_W-1:0] hist_mem [256];
  logic [7:0]       lut_mem  [256];
  logic [255:0]     hvld_r;
  logic [CNT_W-1:0] hist_q_r;
  logic             hv_q_r;
  logic [7:0]       lut_q_r;

  logic [8:0]        cnt_r;
  logic              pv_r;
  logic [7:0]        pa_r;
  logic [CNT_W-1:0]  acc_r;
  logic              found_lo_r, found_p_r;
  logic [7:0]        lo_r, hi_r, pmin_r, pmax_r;
  logic [24:0]       prod_r;
  logic [7:0]        rem_r, quo_r, qd_r, rm_r, fq_r, fr_r;
  logic [2:0]        dcnt_r;
  logic [NEED_W-1:0] need_r;
  logic              empty_r;
  logic              done_r;

  logic             scanning, scan_end;
  logic [7:0]       scan_addr, rd_addr;
  logic [CNT_W-1:0] bin, acc_sum;
  logic             reach, nz;
  logic [7:0]       delta, lo_new, hi_new, dvs, fi, fill_val, mid_val;
  logic [8:0]       hi_ext, rem_sh, fr_sum;
  logic             ge, fr_wrap, middle;

  always_comb begin
    scanning  = (state_r == L_UP) || (state_r == L_DOWN);
    scan_end  = cnt_r[8] && !pv_r;
    scan_addr = (state_r == L_UP) ? cnt_r[7:0] : ~cnt_r[7:0];
    rd_addr   = scanning ? scan_addr : pix;
    bin       = hv_q_r ? hist_q_r : '0;
    nz        = (bin != '0);
    acc_sum   = acc_r + bin;
    reach     = NEED_W'({acc_sum, 16'h0}) >= need_r;
    delta     = prod_r[24:17];
    lo_new    = (lo_r >= delta) ? lo_r - delta : 8'd0;
    hi_ext    = {1'b0, hi_r} + {1'b0, delta};
    hi_new    = hi_ext[8] ? 8'hFF : hi_ext[7:0];
    dvs       = pmax_r - pmin_r;
    rem_sh    = {rem_r, quo_r[7]};
    ge        = rem_sh >= {1'b0, dvs};
    fi        = cnt_r[7:0];
    fr_sum    = {1'b0, fr_r} + {1'b0, rm_r};
    fr_wrap   = fr_sum >= {1'b0, dvs};
    mid_val   = lo_r + fq_r;
    middle    = 1'b0;
    if (pmin_r == pmax_r) begin
      fill_val = pmax_r;
    end else if (fi < pmin_r) begin
      fill_val = lo_r;
    end else if (fi > pmax_r) begin
      fill_val = hi_r;
    end else begin
      fill_val = mid_val;
      middle   = 1'b1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      L_IDLE:  if (cmd.build) state_nxt = L_UP;
      L_UP:    if (scan_end) state_nxt = L_DOWN;
      L_DOWN:  if (scan_end) state_nxt = L_MUL;
      L_MUL:   state_nxt = L_CLAMP;
      L_CLAMP: state_nxt = L_DIV;
      L_DIV:   if (dcnt_r == 3'd7) state_nxt = L_FILL;
      L_FILL:  if (fi == 8'hFF) state_nxt = L_IDLE;
      default: state_nxt = L_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= L_IDLE;
      pv_r    <= 1'b0;
      done_r  <= 1'b0;
      hvld_r  <= '0;
    end else begin
      state_r <= state_nxt;
      pv_r    <= scanning && !cnt_r[8];
      done_r  <= (state_r == L_FILL) && (fi == 8'hFF);
      if (cmd.incr) begin
        hvld_r[pix] <= 1'b1;
      end else if (state_r == L_DOWN && scan_end) begin
        hvld_r <= '0;
      end
    end
  end

  // Histogram and table stores
  always_ff @(posedge clk) begin
    if (cmd.incr) begin
      hist_mem[pix] <= bin + CNT_W'(1);
    end
    hist_q_r <= hist_mem[rd_addr];
    hv_q_r   <= hvld_r[rd_addr];
    if (state_r == L_FILL) begin
      lut_mem[fi] <= fill_val;
    end
    lut_q_r <= lut_mem[pix];
  end

  always_ff @(posedge clk) begin
    pa_r <= scan_addr;
    case (state_r)
      L_IDLE: begin
        if (cmd.build) begin
          cnt_r      <= '0;
          acc_r      <= '0;
          found_lo_r <= 1'b0;
          found_p_r  <= 1'b0;
          lo_r       <= 8'd0;
          hi_r       <= 8'hFF;
          pmin_r     <= 8'd0;
          pmax_r     <= 8'hFF;
          need_r     <= need;
          empty_r    <= cmd.empty;
        end
      end
      L_UP: begin
        if (!cnt_r[8]) cnt_r <= cnt_r + 9'd1;
        if (pv_r) begin
          acc_r <= acc_sum;
          if (nz && !found_lo_r) begin
            lo_r       <= pa_r;
            found_lo_r <= 1'b1;
          end
          if (nz) hi_r <= pa_r;
          if ((found_lo_r || nz || empty_r) && !found_p_r && reach) begin
            pmin_r    <= pa_r;
            found_p_r <= 1'b1;
          end
        end
        if (scan_end) begin
          cnt_r     <= '0;
          acc_r     <= '0;
          found_p_r <= 1'b0;
        end
      end
      L_DOWN: begin
        if (!cnt_r[8]) cnt_r <= cnt_r + 9'd1;
        if (pv_r) begin
          acc_r <= acc_sum;
          if (!found_p_r && reach) begin
            pmax_r    <= pa_r;
            found_p_r <= 1'b1;
          end
        end
      end
      L_MUL: begin
        prod_r <= 25'(hi_r - lo_r) * 25'(gain);
      end
      L_CLAMP: begin
        lo_r   <= lo_new;
        hi_r   <= hi_new;
        quo_r  <= hi_new - lo_new;
        rem_r  <= 8'd0;
        dcnt_r <= 3'd0;
      end
      L_DIV: begin
        // One quotient bit a step
        rem_r  <= ge ? 8'(rem_sh - {1'b0, dvs}) : rem_sh[7:0];
        quo_r  <= {quo_r[6:0], ge};
        dcnt_r <= dcnt_r + 3'd1;
        if (dcnt_r == 3'd7) begin
          qd_r  <= {quo_r[6:0], ge};
          rm_r  <= ge ? 8'(rem_sh - {1'b0, dvs}) : rem_sh[7:0];
          fq_r  <= 8'd0;
          fr_r  <= 8'd0;
          cnt_r <= '0;
        end
      end
      L_FILL: begin
        cnt_r <= cnt_r + 9'd1;
        // Step the ramp by quotient and carried remainder
        if (middle) begin
          if (fr_wrap) begin
            fr_r <= 8'(fr_sum - {1'b0, dvs});
            fq_r <= fq_r + qd_r + 8'd1;
          end else begin
            fr_r <= fr_sum[7:0];
            fq_r <= fq_r + qd_r;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign lut_q = lut_q_r;
  assign done  = done_r;

endmodule

// ----- src/awbl_cast.sv -----
// Colour cast decision: mean chroma offsets by an eight step divider.
// Depends on awbl_pkg.
module awbl_cast import awbl_pkg::*; #(
  parameter int PIXEL_COUNT_BITS = AWBL_PIXEL_COUNT_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [PIXEL_COUNT_BITS+7:0]  cb_sum,
  input  logic [PIXEL_COUNT_BITS+7:0]  cr_sum,
  input  logic [PIXEL_COUNT_BITS:0]    n,
  input  logic [7:0]                   thr,
  output logic                         done,
  output logic                         cast
);

  localparam int SUM_W = PIXEL_COUNT_BITS + 8;

  awbl_cast_state_t state_r, state_nxt;
  logic [SUM_W-1:0] cb_r, cr_r, n_r, dsh_r;
  logic [7:0]       qcb_r, qcr_r;
  logic [2:0]       k_r;
  logic             cast_r, done_r;
  logic [SUM_W-1:0] base;
  logic             ge_cb, ge_cr;
  logic [8:0]       qsum;

  always_comb begin
    base  = (n_r << 7) - n_r;
    ge_cb = cb_r >= dsh_r;
    ge_cr = cr_r >= dsh_r;
    qsum  = {1'b0, qcb_r} + {1'b0, qcr_r};
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      C_IDLE:  if (start) state_nxt = C_PREP;
      C_PREP:  state_nxt = C_DIV;
      C_DIV:   if (k_r == 3'd7) state_nxt = C_FIN;
      C_FIN:   state_nxt = C_IDLE;
      default: state_nxt = C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      done_r  <= 1'b0;
      cast_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= (state_r == C_FIN);
      if (state_r == C_FIN) begin
        cast_r <= (n_r != '0) && (qsum >= {1'b0, thr});
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      C_IDLE: begin
        if (start) begin
          cb_r <= cb_sum;
          cr_r <= cr_sum;
          n_r  <= SUM_W'(n);
        end
      end
      C_PREP: begin
        // Distance from the mid level, then divide by the count
        cb_r  <= (cb_r >= base) ? cb_r - base : base - cb_r;
        cr_r  <= (cr_r >= base) ? cr_r - base : base - cr_r;
        dsh_r <= n_r << 7;
        qcb_r <= 8'd0;
        qcr_r <= 8'd0;
        k_r   <= 3'd0;
      end
      C_DIV: begin
        if (ge_cb) cb_r <= cb_r - dsh_r;
        if (ge_cr) cr_r <= cr_r - dsh_r;
        qcb_r <= {qcb_r[6:0], ge_cb};
        qcr_r <= {qcr_r[6:0], ge_cr};
        dsh_r <= dsh_r >> 1;
        k_r   <= k_r + 3'd1;
      end
      default: begin
      end
    endcase
  end

  assign done = done_r;
  assign cast = cast_r;

endmodule

// ----- src/auto_white_balance_levels_core.sv -----
// Top level of the auto white balance levels block: control, statistics and merge.
// Depends on awbl_pkg, awbl_lane and awbl_cast.

// One item is in flight at a time. A gather pixel passes states G1 to G4 after
// acceptance (colour conversion multipliers and the histogram read-modify-write),
// an apply pixel APPLY and EMIT (table read and output load). After the last
// gather pixel of a frame, each of the three channel lanes scans its histogram
// memory upward and then downward at one bin a cycle, runs an eight step divide
// and writes its 256-entry lookup table one entry a cycle, with the colour cast
// divider running alongside. The output register lets the next item be accepted
// while a result is still waiting. No clearing pass is needed after reset.
module auto_white_balance_levels_core import awbl_pkg::*; #(
  parameter int PIXEL_COUNT_BITS = AWBL_PIXEL_COUNT_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  awbl_in_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output awbl_out_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_data
);

  localparam int CNT_W  = PIXEL_COUNT_BITS + 1;
  localparam int SUM_W  = PIXEL_COUNT_BITS + 8;
  localparam int NEED_W = PIXEL_COUNT_BITS + 18;

  awbl_state_t state_r, state_nxt;

  awbl_in_t          pix_r;
  logic [23:0]       pr_r, pg_r, pb_r;
  logic [7:0]        y_r;
  logic signed [26:0] cbp_r, crp_r;
  logic [SUM_W-1:0]  cb_sum_r, cr_sum_r;
  logic [CNT_W-1:0]  count_r;
  logic [NEED_W-1:0] need_r;
  logic [7:0]        thr_r;
  logic [16:0]       cut_r, gain_r;
  logic              cast_flag_r;
  logic [2:0]        ldone_r;
  logic              cdone_r;
  logic              out_valid_r;
  awbl_out_t         out_data_r;

  awbl_lane_cmd_t    lcmd;
  logic [7:0]        lut_r, lut_g, lut_b;
  logic [2:0]        lane_done;
  logic              cast_done, cast_res;
  logic              accept, load;
  logic [23:0]       ysum;
  logic signed [8:0] cbd, crd;
  logic [7:0]        cb8, cr8;
  awbl_out_t         res;

  always_comb begin
    accept    = in_valid && !in_stall;
    load      = (state_r == S_EMIT) && (!out_valid_r || !out_stall);
    ysum      = pr_r + pg_r + pb_r;
    cbd       = $signed({1'b0, pix_r.blue}) - $signed({1'b0, y_r});
    crd       = $signed({1'b0, pix_r.red}) - $signed({1'b0, y_r});
    cb8       = cbp_r[23:16] + AWBL_CHROMA_OFS;
    cr8       = crp_r[23:16] + AWBL_CHROMA_OFS;
    lcmd.incr  = (state_r == S_G2) && !count_r[PIXEL_COUNT_BITS];
    lcmd.build = (state_r == S_LAUNCH);
    lcmd.empty = (count_r == '0);
    if (pix_r.req_type == REQ_APPLY) begin
      res.kind       = KIND_PIXEL;
      res.red_out    = cast_flag_r ? lut_r : pix_r.red;
      res.green_out  = cast_flag_r ? lut_g : pix_r.green;
      res.blue_out   = cast_flag_r ? lut_b : pix_r.blue;
    end else begin
      res.kind       = KIND_STATUS;
      res.red_out    = 8'd0;
      res.green_out  = 8'd0;
      res.blue_out   = 8'd0;
    end
    res.color_cast = cast_flag_r;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = (in_data.req_type == REQ_APPLY) ? S_APPLY : S_G1;
        end
      end
      S_G1:     state_nxt = S_G2;
      S_G2:     state_nxt = S_G3;
      S_G3:     state_nxt = S_G4;
      S_G4:     state_nxt = pix_r.last ? S_PREP : S_IDLE;
      S_PREP:   state_nxt = S_LAUNCH;
      S_LAUNCH: state_nxt = S_BUILD;
      S_BUILD:  if ((&ldone_r) && cdone_r) state_nxt = S_EMIT;
      S_APPLY:  state_nxt = S_EMIT;
      S_EMIT:   if (load) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      cb_sum_r    <= '0;
      cr_sum_r    <= '0;
      cast_flag_r <= 1'b0;
      ldone_r     <= '0;
      cdone_r     <= 1'b0;
      out_valid_r <= 1'b0;
      thr_r       <= AWBL_THR_RESET;
      cut_r       <= AWBL_CUT_RESET;
      gain_r      <= AWBL_GAIN_RESET;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          CFG_THRESHOLD: thr_r  <= cfg_data[7:0];
          CFG_CUT:       cut_r  <= cfg_data;
          CFG_GAIN:      gain_r <= cfg_data;
          default: begin
          end
        endcase
      end
      // Drop further pixels once the count is full
      if (state_r == S_G4 && !count_r[PIXEL_COUNT_BITS]) begin
        count_r  <= count_r + CNT_W'(1);
        cb_sum_r <= cb_sum_r + SUM_W'(cb8);
        cr_sum_r <= cr_sum_r + SUM_W'(cr8);
      end
      if (state_r == S_LAUNCH) begin
        ldone_r <= '0;
        cdone_r <= 1'b0;
      end else begin
        ldone_r <= ldone_r | lane_done;
        if (cast_done) cdone_r <= 1'b1;
      end
      if (state_r == S_BUILD && (&ldone_r) && cdone_r) begin
        cast_flag_r <= cast_res;
        count_r     <= '0;
        cb_sum_r    <= '0;
        cr_sum_r    <= '0;
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) pix_r <= in_data;
    pr_r  <= {8'h0, AWBL_Y_R} * {16'h0, pix_r.red};
    pg_r  <= {8'h0, AWBL_Y_G} * {16'h0, pix_r.green};
    pb_r  <= {8'h0, AWBL_Y_B} * {16'h0, pix_r.blue};
    y_r   <= ysum[23:16];
    cbp_r <= $signed({1'b0, AWBL_CB_K}) * cbd;
    crp_r <= $signed({1'b0, AWBL_CR_K}) * crd;
    if (state_r == S_PREP) begin
      need_r <= NEED_W'(count_r * cut_r);
    end
    if (load) out_data_r <= res;
  end

  awbl_lane #(.PIXEL_COUNT_BITS(PIXEL_COUNT_BITS)) u_lane_r (
    .clk(clk), .rst_n(rst_n), .cmd(lcmd), .pix(pix_r.red), .need(need_r),
    .gain(gain_r), .lut_q(lut_r), .done(lane_done[0])
  );

  awbl_lane #(.PIXEL_COUNT_BITS(PIXEL_COUNT_BITS)) u_lane_g (
    .clk(clk), .rst_n(rst_n), .cmd(lcmd), .pix(pix_r.green), .need(need_r),
    .gain(gain_r), .lut_q(lut_g), .done(lane_done[1])
  );

  awbl_lane #(.PIXEL_COUNT_BITS(PIXEL_COUNT_BITS)) u_lane_b (
    .clk(clk), .rst_n(rst_n), .cmd(lcmd), .pix(pix_r.blue), .need(need_r),
    .gain(gain_r), .lut_q(lut_b), .done(lane_done[2])
  );

  awbl_cast #(.PIXEL_COUNT_BITS(PIXEL_COUNT_BITS)) u_cast (
    .clk(clk), .rst_n(rst_n), .start(state_r == S_LAUNCH), .cb_sum(cb_sum_r),
    .cr_sum(cr_sum_r), .n(count_r), .thr(thr_r), .done(cast_done), .cast(cast_res)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

endmodule

// ----- src/awbl_checker.sv -----
// Port-level checks for the auto white balance levels block, with its bind.
// Depends on awbl_pkg and auto_white_balance_levels_core.
module awbl_checker import awbl_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input awbl_out_t out_data
);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken while one is in flight");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == KIND_STATUS |->
      out_data.red_out == 8'd0 && out_data.green_out == 8'd0 &&
      out_data.blue_out == 8'd0)
    else $error("status item carries pixel data");

endmodule

bind auto_white_balance_levels_core awbl_checker u_awbl_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
